FILE: hw/rtl/aks_pkg.sv
// ----------------------------------------------------------------------------
// aks_pkg
// Shared constants and modular arithmetic helpers for the congruence checker.
// ----------------------------------------------------------------------------
package aks_pkg;

  localparam int WideW = 128;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 64;

  typedef logic [WideW-1:0] wide_t;

  localparam logic [CfgIdxW-1:0] REG_MOD_LOW  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MOD_HIGH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RING_DEG = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TOP_BIT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TARGET   = 3'd4;

  // (x + y) mod n for x < n, y <= n
  function automatic wide_t add_mod(input wide_t x, input wide_t y, input wide_t n);
    logic [WideW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, n}) begin
      add_mod = s[WideW-1:0] - n;
    end else begin
      add_mod = s[WideW-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/aks_poly_congruence_check.sv
// ----------------------------------------------------------------------------
// aks_poly_congruence_check
// Computes (x+a)^n mod (x^r-1, n) by square-and-multiply and compares it
// with x^t+a, t being the target register reduced mod r.
// ----------------------------------------------------------------------------
// channel | ports                               | direction
// in      | in_valid in_ready in_witness        | request in
// out     | out_valid out_ready                 | request out
//         | out_congruence_holds                |
// cfg     | cfg_valid cfg_ready cfg_index       | register write in
//         | cfg_data                            |
//
// One request at a time. The multiplier is bit-serial; each exponent bit
// takes a squaring, then a multiply step or a plain copy. n = 0 skips the
// computation and goes straight to the final state, which puts its result
// out once the output register is free.
// Reset is synchronous; coefficient memories are cleared per request, not by reset.
// A stalled result holds in the output register; a new request is taken
// once the engine has handed its result over.
// ----------------------------------------------------------------------------
module aks_poly_congruence_check #(
  parameter int MAX_RING_DEGREE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_witness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_congruence_holds,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int AW = (MAX_RING_DEGREE > 2) ? $clog2(MAX_RING_DEGREE) : 1;
  localparam int LW = $clog2(MAX_RING_DEGREE + 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_TMOD  = 5'd1;
  localparam logic [4:0] ST_AW    = 5'd2;
  localparam logic [4:0] ST_CLR   = 5'd3;
  localparam logic [4:0] ST_BIT   = 5'd4;
  localparam logic [4:0] ST_SQCLR = 5'd5;
  localparam logic [4:0] ST_SQRDI = 5'd6;
  localparam logic [4:0] ST_SQLTI = 5'd7;
  localparam logic [4:0] ST_SQRDJ = 5'd8;
  localparam logic [4:0] ST_SQMUL = 5'd9;
  localparam logic [4:0] ST_SQWT  = 5'd10;
  localparam logic [4:0] ST_SQEND = 5'd11;
  localparam logic [4:0] ST_MLRD  = 5'd12;
  localparam logic [4:0] ST_MLMUL = 5'd13;
  localparam logic [4:0] ST_MLWT  = 5'd14;
  localparam logic [4:0] ST_CPRD  = 5'd15;
  localparam logic [4:0] ST_CPWR  = 5'd16;
  localparam logic [4:0] ST_CMRD  = 5'd17;
  localparam logic [4:0] ST_CMCK  = 5'd18;
  localparam logic [4:0] ST_FIN   = 5'd19;
  localparam logic [4:0] ST_AWST  = 5'd20;

  logic [63:0] mod_low_r, mod_high_r;
  logic [12:0] ring_r;
  logic [6:0]  top_r;
  logic [11:0] target_r;

  logic [4:0]  state_r, state_nxt;
  logic [LW-1:0] r_r, r_nxt, len_r, len_nxt;
  logic [11:0] t_r, t_nxt;
  logic [6:0]  k_r, k_nxt;
  logic [AW-1:0] i_r, i_nxt, j_r, j_nxt;
  aks_pkg::wide_t aw_r, aw_nxt, pi_r, pi_nxt, sq_r, sq_nxt;
  logic        holds_r, holds_nxt;
  logic        ov_r, ov_nxt, od_r, od_nxt;

  aks_pkg::wide_t n_full, onem, p_rdata, s_rdata;
  logic [AW-1:0] p_raddr, s_raddr, p_waddr, s_waddr, idx, prev;
  logic        p_we, s_we;
  aks_pkg::wide_t p_wdata, s_wdata;
  logic        mul_start, mul_done;
  aks_pkg::wide_t mul_a, mul_b, mul_res, expd;
  logic [AW:0] ij_sum;
  logic [LW:0] dbl_len;
  logic        i_last_r, i_last_len, j_last_len;

  aks_pkg::wide_t pmem [MAX_RING_DEGREE];
  aks_pkg::wide_t smem [MAX_RING_DEGREE];

  assign n_full = {mod_high_r, mod_low_r};
  assign onem   = (n_full == aks_pkg::wide_t'(1)) ? '0 : aks_pkg::wide_t'(1);

  assign ij_sum = {1'b0, i_r} + {1'b0, j_r};
  assign idx    = ({1'b0, ij_sum} >= {1'b0, r_r}) ? AW'(ij_sum - (AW+1)'(r_r))
                                                  : ij_sum[AW-1:0];
  assign prev   = (i_r == '0) ? AW'(r_r - LW'(1)) : (i_r - AW'(1));
  assign dbl_len = {len_r, 1'b0} - (LW+1)'(1);
  assign i_last_r   = (LW'(i_r) + LW'(1)) == r_r;
  assign i_last_len = (LW'(i_r) + LW'(1)) == len_r;
  assign j_last_len = (LW'(j_r) + LW'(1)) == len_r;

  always_comb begin
    if (i_r == '0) begin
      expd = (t_r == '0) ? aks_pkg::add_mod(onem, aw_r, n_full) : aw_r;
    end else if (14'(i_r) == 14'(t_r)) begin
      expd = onem;
    end else begin
      expd = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    len_nxt = len_r;
    t_nxt = t_r;
    k_nxt = k_r;
    i_nxt = i_r;
    j_nxt = j_r;
    aw_nxt = aw_r;
    pi_nxt = pi_r;
    sq_nxt = sq_r;
    holds_nxt = holds_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    p_raddr = i_r;
    s_raddr = i_r;
    p_we = 1'b0;
    s_we = 1'b0;
    p_waddr = i_r;
    s_waddr = i_r;
    p_wdata = '0;
    s_wdata = '0;
    mul_start = 1'b0;
    mul_a = aw_r;
    mul_b = s_rdata;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          holds_nxt = 1'b1;
          t_nxt = target_r;
          aw_nxt = aks_pkg::wide_t'(in_witness);
          if ({1'b0, ring_r} < 14'd2) begin
            r_nxt = LW'(2);
          end else if ({1'b0, ring_r} > 14'(MAX_RING_DEGREE)) begin
            r_nxt = LW'(MAX_RING_DEGREE);
          end else begin
            r_nxt = LW'(ring_r);
          end
          if (n_full == '0) begin
            holds_nxt = 1'b0;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_TMOD;
          end
        end
      end
      ST_TMOD: begin
        if (14'(t_r) >= 14'(r_r)) begin
          t_nxt = 12'(14'(t_r) - 14'(r_r));
        end else begin
          state_nxt = ST_AWST;
        end
      end
      ST_AWST: begin
        mul_start = 1'b1;
        mul_a = onem;
        mul_b = aw_r;
        state_nxt = ST_AW;
      end
      ST_AW: begin
        if (mul_done) begin
          aw_nxt = mul_res;
          i_nxt = '0;
          state_nxt = ST_CLR;
        end
      end
      ST_CLR: begin
        p_we = 1'b1;
        p_wdata = (i_r == '0) ? aw_r : ((i_r == AW'(1)) ? onem : '0);
        i_nxt = i_r + AW'(1);
        if (i_last_r) begin
          len_nxt = LW'(2);
          k_nxt = top_r;
          state_nxt = ST_BIT;
        end
      end
      ST_BIT: begin
        i_nxt = '0;
        j_nxt = '0;
        if (k_r == '0) begin
          state_nxt = ST_CMRD;
        end else begin
          k_nxt = k_r - 7'd1;
          state_nxt = ST_SQCLR;
        end
      end
      ST_SQCLR: begin
        s_we = 1'b1;
        i_nxt = i_r + AW'(1);
        if (i_last_r) begin
          i_nxt = '0;
          j_nxt = '0;
          state_nxt = ST_SQRDI;
        end
      end
      ST_SQRDI: begin
        state_nxt = ST_SQLTI;
      end
      ST_SQLTI: begin
        pi_nxt = p_rdata;
        state_nxt = ST_SQRDJ;
      end
      ST_SQRDJ: begin
        p_raddr = j_r;
        s_raddr = idx;
        state_nxt = ST_SQMUL;
      end
      ST_SQMUL: begin
        mul_start = 1'b1;
        mul_a = pi_r;
        mul_b = p_rdata;
        sq_nxt = s_rdata;
        state_nxt = ST_SQWT;
      end
      ST_SQWT: begin
        if (mul_done) begin
          s_we = 1'b1;
          s_waddr = idx;
          s_wdata = aks_pkg::add_mod(sq_r, mul_res, n_full);
          j_nxt = j_r + AW'(1);
          state_nxt = ST_SQRDJ;
          if (j_last_len) begin
            j_nxt = '0;
            i_nxt = i_r + AW'(1);
            state_nxt = ST_SQRDI;
            if (i_last_len) begin
              state_nxt = ST_SQEND;
            end
          end
        end
      end
      ST_SQEND: begin
        i_nxt = '0;
        len_nxt = (dbl_len > (LW+1)'(r_r)) ? r_r : LW'(dbl_len);
        state_nxt = n_full[k_r] ? ST_MLRD : ST_CPRD;
      end
      ST_MLRD: begin
        state_nxt = ST_MLMUL;
      end
      ST_MLMUL: begin
        mul_start = 1'b1;
        s_raddr = prev;
        state_nxt = ST_MLWT;
      end
      ST_MLWT: begin
        s_raddr = prev;
        if (mul_done) begin
          p_we = 1'b1;
          p_wdata = aks_pkg::add_mod(mul_res, s_rdata, n_full);
          i_nxt = i_r + AW'(1);
          state_nxt = ST_MLRD;
          if (i_last_r) begin
            len_nxt = (len_r == r_r) ? r_r : (len_r + LW'(1));
            state_nxt = ST_BIT;
          end
        end
      end
      ST_CPRD: begin
        state_nxt = ST_CPWR;
      end
      ST_CPWR: begin
        p_we = 1'b1;
        p_wdata = s_rdata;
        i_nxt = i_r + AW'(1);
        state_nxt = i_last_r ? ST_BIT : ST_CPRD;
      end
      ST_CMRD: begin
        state_nxt = ST_CMCK;
      end
      ST_CMCK: begin
        if (p_rdata != expd) begin
          holds_nxt = 1'b0;
        end
        i_nxt = i_r + AW'(1);
        state_nxt = i_last_r ? ST_FIN : ST_CMRD;
      end
      ST_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt = holds_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  aks_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .n     (n_full),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ov_r       <= 1'b0;
      mod_low_r  <= '0;
      mod_high_r <= '0;
      ring_r     <= 13'd2;
      top_r      <= '0;
      target_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          aks_pkg::REG_MOD_LOW:  mod_low_r  <= cfg_data;
          aks_pkg::REG_MOD_HIGH: mod_high_r <= cfg_data;
          aks_pkg::REG_RING_DEG: ring_r     <= cfg_data[12:0];
          aks_pkg::REG_TOP_BIT:  top_r      <= cfg_data[6:0];
          aks_pkg::REG_TARGET:   target_r   <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
    r_r     <= r_nxt;
    len_r   <= len_nxt;
    t_r     <= t_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    aw_r    <= aw_nxt;
    pi_r    <= pi_nxt;
    sq_r    <= sq_nxt;
    holds_r <= holds_nxt;
    od_r    <= od_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_congruence_holds = od_r;

endmodule

FILE: hw/rtl/aks_mulmod.sv
// ----------------------------------------------------------------------------
// aks_mulmod
// Bit-serial modular multiplier: double-and-add over the 128 bits of b.
// ----------------------------------------------------------------------------
module aks_mulmod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  aks_pkg::wide_t a,
  input  aks_pkg::wide_t b,
  input  aks_pkg::wide_t n,
  output logic          done,
  output aks_pkg::wide_t res
);

  aks_pkg::wide_t a_r, b_r, res_r;
  aks_pkg::wide_t a_nxt, b_nxt, res_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic       phase_r, phase_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    if (start) begin
      a_nxt     = a;
      b_nxt     = b;
      res_nxt   = '0;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (busy_r) begin
      if (!phase_r) begin
        res_nxt   = aks_pkg::add_mod(res_r, res_r, n);
        phase_nxt = 1'b1;
      end else begin
        if (b_r[aks_pkg::WideW-1]) begin
          res_nxt = aks_pkg::add_mod(res_r, a_r, n);
        end
        b_nxt     = {b_r[aks_pkg::WideW-2:0], 1'b0};
        phase_nxt = 1'b0;
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/aks_check.sv
// ----------------------------------------------------------------------------
// aks_check
// Port-level checks for the congruence checker.
// ----------------------------------------------------------------------------
module aks_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_congruence_holds
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_congruence_holds))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while engine busy");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aks_poly_congruence_check aks_check u_aks_check (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_congruence_holds (out_congruence_holds)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the polynomial congruence checker: register writes over the config
// port, directed corner requests, then random request streams with random
// stalls on both sides, each result compared against a fixed expected value
// or a modular-arithmetic model of (x+a)^n mod (x^r-1, n).
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MaxRing = 4096;
  localparam int IdleLimit = 1500000;

  typedef struct {
    bit          cfg;
    logic [63:0] lo;
    logic [63:0] hi;
    int          ring;
    int          top;
    int          tgt;
    logic [31:0] wit;
    int          want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_witness = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_congruence_holds;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] n_lo = '0;
  logic [63:0] n_hi = '0;
  logic [12:0] ring_deg = 13'd2;
  logic [6:0]  top_idx = '0;
  logic [11:0] tgt_exp = '0;

  bit holds_q[$];
  bit bad = 1'b0;
  int idle_cnt = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  dir_row_t dir_tab[15];

  aks_poly_congruence_check uut (.*);

  always #2 clk = ~clk;

  function automatic aks_pkg::wide_t add_m(input aks_pkg::wide_t x, input aks_pkg::wide_t y,
                                           input aks_pkg::wide_t n);
    logic [128:0] s;
    s = {1'b0, x} + {1'b0, y};
    return aks_pkg::wide_t'(s % {1'b0, n});
  endfunction

  function automatic aks_pkg::wide_t mul_m(input aks_pkg::wide_t x, input aks_pkg::wide_t y,
                                           input aks_pkg::wide_t n);
    logic [255:0] p;
    p = {128'b0, x} * {128'b0, y};
    return aks_pkg::wide_t'(p % {128'b0, n});
  endfunction

  function automatic bit predict_holds(input logic [31:0] w);
    aks_pkg::wide_t n, a, one, e;
    aks_pkg::wide_t pw[], sq[];
    int r, t, idx, prev;
    n = {n_hi, n_lo};
    if (n == '0) return 1'b0;
    r = int'(ring_deg);
    if (r < 2) r = 2;
    if (r > MaxRing) r = MaxRing;
    t = int'(tgt_exp) % r;
    a = {96'b0, w} % n;
    one = aks_pkg::wide_t'(1) % n;
    pw = new[r];
    sq = new[r];
    foreach (pw[i]) pw[i] = '0;
    pw[0] = a;
    pw[1] = one;
    for (int k = int'(top_idx) - 1; k >= 0; k--) begin
      foreach (sq[i]) sq[i] = '0;
      for (int i = 0; i < r; i++) begin
        for (int j = 0; j < r; j++) begin
          idx = (i + j) % r;
          sq[idx] = add_m(sq[idx], mul_m(pw[i], pw[j], n), n);
        end
      end
      for (int i = 0; i < r; i++) begin
        prev = (i == 0) ? r - 1 : i - 1;
        pw[i] = n[k] ? add_m(mul_m(a, sq[i], n), sq[prev], n) : sq[i];
      end
    end
    for (int i = 0; i < r; i++) begin
      e = '0;
      if (i == t) e = one;
      if (i == 0) e = (t == 0) ? add_m(one, a, n) : a;
      if (pw[i] != e) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      aks_pkg::REG_MOD_LOW:  n_lo = data;
      aks_pkg::REG_MOD_HIGH: n_hi = data;
      aks_pkg::REG_RING_DEG: ring_deg = data[12:0];
      aks_pkg::REG_TOP_BIT:  top_idx = data[6:0];
      aks_pkg::REG_TARGET:   tgt_exp = data[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(input logic [63:0] lo, input logic [63:0] hi, input int ring,
                       input int top, input int tgt);
    @(negedge clk);
    in_valid <= 1'b0;
    while (holds_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    write_reg(aks_pkg::REG_MOD_LOW, lo);
    write_reg(aks_pkg::REG_MOD_HIGH, hi);
    write_reg(aks_pkg::REG_RING_DEG, 64'(ring));
    write_reg(aks_pkg::REG_TOP_BIT, 64'(top));
    write_reg(aks_pkg::REG_TARGET, 64'(tgt));
  endtask

  task automatic send_witness(input logic [31:0] w, input int gap, input int want);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_witness <= w;
    do @(posedge clk); while (!in_ready);
    holds_q.push_back(want >= 0 ? bit'(want) : predict_holds(w));
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 11) == 0) return $urandom_range(20, 200);
    return $urandom_range(0, 2);
  endfunction

  function automatic int msb_of(input logic [63:0] v);
    int m;
    m = 0;
    for (int i = 0; i < 64; i++) if (v[i]) m = i;
    return m;
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(20, 200);
      end
      burst_left = burst_left - 1;
      if (calm) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 15) == 0) begin
        hold_left <= $urandom_range(10, 60);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (holds_q.size() == 0) begin
        $error("unexpected result, congruence_holds=%0d", out_congruence_holds);
        bad = 1'b1;
      end else begin
        bit want;
        want = holds_q.pop_front();
        if (out_congruence_holds !== want) begin
          $error("congruence_holds: expected %0d, actual %0d", want,
                 out_congruence_holds);
          bad = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt == IdleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    logic [63:0] lo, hi;
    int ring, top, tgt;

    // cfg, lo, hi, ring, top, target, witness, expected (-1: from model)
    dir_tab = '{
      '{1'b0, 64'd0, 64'd0, 2, 0, 0, 32'h1234_5678, 0},
      '{1'b1, 64'd0, 64'd0, 4096, 127, 4095, 32'hffff_ffff, 0},
      '{1'b1, 64'd0, 64'd0, 0, 0, 0, 32'h0, 0},
      '{1'b1, 64'd0, 64'd0, 8191, 127, 4095, 32'h8000_0001, 0},
      '{1'b1, 64'd1, 64'd0, 2, 0, 0, 32'h0, 1},
      '{1'b1, 64'd1, 64'd0, 3, 0, 1, 32'hffff_ffff, 1},
      '{1'b1, 64'd2, 64'd0, 2, 1, 0, 32'h3, -1},
      '{1'b1, 64'd7, 64'd0, 3, 2, 1, 32'h3, -1},
      '{1'b1, 64'd9, 64'd0, 2, 3, 1, 32'h2, -1},
      '{1'b1, 64'd5, 64'd0, 3, 2, 2, 32'd12, -1},
      '{1'b1, 64'd5, 64'd0, 2, 2, 4095, 32'd1, -1},
      '{1'b1, 64'd13, 64'd0, 3, 0, 1, 32'd7, -1},
      '{1'b1, 64'd7, 64'd0, 0, 2, 1, 32'd4, -1},
      '{1'b1, '1, '1, 2, 0, 1, 32'hffff_ffff, -1},
      '{1'b1, '1, 64'h7fff_ffff_ffff_ffff, 2, 126, 1, 32'd5, -1}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].cfg)
        setup(dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].ring, dir_tab[i].top,
              dir_tab[i].tgt);
      send_witness(dir_tab[i].wit, rand_gap(), dir_tab[i].want);
    end

    // result side held off while n = 0 answers fast, so the input backs up
    setup(64'd0, 64'd0, 2, 0, 0);
    hold_req = hold_req + 1;
    repeat (12) send_witness($urandom, 0, -1);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph % 3 == 2) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        top = $urandom_range(0, 4);
        ring = $urandom_range(2, 3);
        tgt = $urandom_range(0, 4095);
      end else begin
        lo = $urandom_range(2, 63);
        hi = '0;
        top = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : msb_of(lo);
        ring = ($urandom_range(0, 4) == 0) ? 4 : $urandom_range(2, 3);
        tgt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : int'(lo % ring);
      end
      setup(lo, hi, ring, top, tgt);
      repeat (12) begin
        send_witness(($urandom_range(0, 7) == 0) ? $urandom_range(0, 70) : $urandom,
                     rand_gap(), -1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (holds_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!bad)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: aks_poly_congruence_check.f
hw/rtl/aks_pkg.sv
hw/rtl/aks_mulmod.sv
hw/rtl/aks_poly_congruence_check.sv
hw/rtl/aks_check.sv
bench/tb_top.sv
